// ----- src/matrix_product_modes_defines.svh -----
// Assertion macros shared by the matrix product block.
`ifndef MATRIX_PRODUCT_MODES_DEFINES_SVH
`define MATRIX_PRODUCT_MODES_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mpm_pkg.sv -----
// Shared types, constants and helpers of the matrix product block.
package mpm_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 2;
  localparam int DIM_REG_W  = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B       = 3'd3;

  // Product modes; the spare code behaves as matrix mode.
  localparam logic [MODE_W-1:0] MODE_MATRIX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ELEM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCALAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clear;
  } mac_ctrl_t;

  // A zero dimension counts as one, a large one is clipped to the maximum.
  function automatic logic [DIM_REG_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] d,
                                                   input int max_d);
    logic [DIM_REG_W-1:0] res;
    res = d;
    if (d == '0) begin
      res = DIM_REG_W'(1);
    end else if (int'(d) > max_d) begin
      res = DIM_REG_W'(max_d);
    end
    return res;
  endfunction

endpackage

// ----- src/mpm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module mpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mpm_mac.sv -----
// Shared multiply-accumulate unit with truncation and saturation of the sum.
module mpm_mac #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DIM    = 8
) (
  input  logic                  clk,
  input  mpm_pkg::mac_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0] a_data,
  input  logic [DATA_WIDTH-1:0] b_data,
  output logic [DATA_WIDTH-1:0] result,
  output logic                  sat
);
  import mpm_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int TOP_W  = ACC_W - DATA_WIDTH + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic [TOP_W-1:0]         upper;
  logic                     fits;

  // Product register: one multiplication per term.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= $signed(a_data) * $signed(b_data);
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Exact accumulator; the first term of an element overwrites it.
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      if (ctrl.acc_clear) begin
        acc <= prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  // Truncate toward minus infinity, then clip to the data range.
  assign shifted = acc >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_WIDTH-1];
  assign fits    = (&upper) || !(|upper);

  always_comb begin
    if (fits) begin
      result = shifted[DATA_WIDTH-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      result = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  assign sat = !fits;

endmodule

// ----- src/mpm_seq.sv -----
// Sequencer: walks the result elements and their terms and drives the shared unit.
module mpm_seq #(
  parameter int MAX_DIM = 8,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [mpm_pkg::MODE_W-1:0]         mode,
  input  logic [mpm_pkg::DIM_REG_W-1:0]      dim_r,
  input  logic [mpm_pkg::DIM_REG_W-1:0]      dim_k,
  input  logic [mpm_pkg::DIM_REG_W-1:0]      dim_c,
  input  logic                               out_free,
  output logic [ADDR_W-1:0]                  a_addr,
  output logic [ADDR_W-1:0]                  b_addr,
  output mpm_pkg::mac_ctrl_t                 ctrl,
  output logic                               emit,
  output logic                               last,
  output logic                               busy
);
  import mpm_pkg::*;

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state;
  logic [DIM_W-1:0]  row;
  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  term;
  logic [ADDR_W-1:0] b_base;
  logic [ADDR_W-1:0] idx;

  logic              row_end;
  logic              col_end;
  logic              term_end;
  logic [DIM_W-1:0]  row_next;
  logic [DIM_W-1:0]  col_next;
  logic [ADDR_W-1:0] b_base_next;
  logic [ADDR_W-1:0] idx_next;

  // Position tests within the result and within the current sum.
  assign row_end  = (DIM_REG_W'(row) == dim_r - DIM_REG_W'(1));
  assign col_end  = (DIM_REG_W'(col) == dim_c - DIM_REG_W'(1));
  assign term_end = (mode != MODE_MATRIX) || (DIM_REG_W'(term) == dim_k - DIM_REG_W'(1));
  assign last     = row_end && col_end;

  // Column-major step to the following result element.
  always_comb begin
    row_next    = row + DIM_W'(1);
    col_next    = col;
    b_base_next = b_base;
    idx_next    = idx + ADDR_W'(1);
    if (row_end) begin
      row_next    = '0;
      col_next    = col + DIM_W'(1);
      b_base_next = b_base + ADDR_W'(dim_k);
    end
  end

  assign busy           = (state != S_IDLE);
  assign emit           = (state == S_FIN) && out_free;
  assign ctrl.mul_en    = (state == S_MUL);
  assign ctrl.acc_en    = (state == S_ACC);
  assign ctrl.acc_clear = (term == '0);

  // Main sequencer with its counters and operand pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      row    <= '0;
      col    <= '0;
      term   <= '0;
      b_base <= '0;
      idx    <= '0;
      a_addr <= '0;
      b_addr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            row    <= '0;
            col    <= '0;
            term   <= '0;
            b_base <= '0;
            idx    <= '0;
            a_addr <= '0;
            b_addr <= '0;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (term_end) begin
            state <= S_FIN;
          end else begin
            term   <= term + DIM_W'(1);
            a_addr <= a_addr + ADDR_W'(dim_r);
            b_addr <= b_addr + ADDR_W'(1);
            state  <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              row    <= row_next;
              col    <= col_next;
              b_base <= b_base_next;
              idx    <= idx_next;
              term   <= '0;
              case (mode)
                MODE_ELEM: begin
                  a_addr <= idx_next;
                  b_addr <= idx_next;
                end
                MODE_SCALAR: begin
                  a_addr <= '0;
                  b_addr <= idx_next;
                end
                default: begin
                  a_addr <= ADDR_W'(row_next);
                  b_addr <= b_base_next;
                end
              endcase
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/matrix_product_modes.sv -----
// Top level of the fixed-point matrix, elementwise and scalar product block.
//
//  Channel   Direction  Handshake              Payload
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//  element   in         element_valid/_stall   element_value
//  product   out        product_valid/_stall   product_value, last_of_run, saturated
//
// Loading takes one element beat per cycle while not stalled, column-major, first
// operand first. Once all are in, each result element goes through the single
// shared multiplier and the registered operand RAM read, one read, multiply and
// accumulate per term (one term outside matrix mode); the element channel stalls
// throughout. The next run may load while the final result beat still waits.
// Reset is synchronous and clears the registers, the load count and the
// sequencer; the operand stores are not cleared. Output stalls hold the sequencer.
`include "matrix_product_modes_defines.svh"

module matrix_product_modes #(
  parameter int MAX_DIM    = mpm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mpm_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mpm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               element_valid,
  output logic                               element_stall,
  input  logic signed [DATA_WIDTH-1:0]       element_value,
  output logic                               product_valid,
  input  logic                               product_stall,
  output logic signed [DATA_WIDTH-1:0]       product_value,
  output logic                               last_of_run,
  output logic                               saturated
);
  import mpm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LC_W   = $clog2(2 * DEPTH + 1);

  logic [MODE_W-1:0]    product_mode;
  logic [DIM_REG_W-1:0] rows_a;
  logic [DIM_REG_W-1:0] inner_dim;
  logic [DIM_REG_W-1:0] cols_b;
  logic [LC_W-1:0]      load_count;

  logic                 cfg_hit;
  logic [MODE_W-1:0]    mode_eff;
  logic [DIM_REG_W-1:0] r_eff;
  logic [DIM_REG_W-1:0] k_eff;
  logic [DIM_REG_W-1:0] c_eff;
  logic [LC_W-1:0]      n_first;
  logic [LC_W-1:0]      n_second;
  logic [LC_W-1:0]      n_total;
  logic                 in_first;
  logic                 accept;
  logic                 start;

  logic [ADDR_W-1:0]     a_raddr;
  logic [ADDR_W-1:0]     b_raddr;
  logic [DATA_WIDTH-1:0] a_rdata;
  logic [DATA_WIDTH-1:0] b_rdata;
  mac_ctrl_t             mac_ctrl;
  logic [DATA_WIDTH-1:0] mac_result;
  logic                  mac_sat;
  logic                  emit;
  logic                  seq_last;
  logic                  busy;
  logic                  out_free;

  // Configuration registers; a write to a known register restarts loading.
  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_index)
      REG_PRODUCT_MODE, REG_ROWS_A, REG_INNER_DIM, REG_COLS_B: cfg_hit = cfg_valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product_mode <= MODE_MATRIX;
      rows_a       <= DIM_REG_W'(1);
      inner_dim    <= DIM_REG_W'(1);
      cols_b       <= DIM_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRODUCT_MODE: product_mode <= cfg_data[MODE_W-1:0];
        REG_ROWS_A:       rows_a       <= cfg_data[DIM_REG_W-1:0];
        REG_INNER_DIM:    inner_dim    <= cfg_data[DIM_REG_W-1:0];
        REG_COLS_B:       cols_b       <= cfg_data[DIM_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective mode and dimensions, and the operand sizes they imply.
  assign mode_eff = (product_mode == MODE_SPARE) ? MODE_MATRIX : product_mode;
  assign r_eff    = eff_dim(rows_a, MAX_DIM);
  assign k_eff    = eff_dim(inner_dim, MAX_DIM);
  assign c_eff    = eff_dim(cols_b, MAX_DIM);

  always_comb begin
    case (mode_eff)
      MODE_ELEM: begin
        n_first  = LC_W'({4'd0, r_eff} * {4'd0, c_eff});
        n_second = n_first;
      end
      MODE_SCALAR: begin
        n_first  = LC_W'(1);
        n_second = LC_W'({4'd0, r_eff} * {4'd0, c_eff});
      end
      default: begin
        n_first  = LC_W'({4'd0, r_eff} * {4'd0, k_eff});
        n_second = LC_W'({4'd0, k_eff} * {4'd0, c_eff});
      end
    endcase
  end

  assign n_total = n_first + n_second;

  // Element loading: one beat per cycle while idle, first store, then second store.
  assign element_stall = busy;
  assign accept        = element_valid && !element_stall;
  assign in_first      = (load_count < n_first);
  assign start         = accept && (load_count + LC_W'(1) == n_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cfg_hit || start) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= load_count + LC_W'(1);
    end
  end

  mpm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_first_store (
    .clk   (clk),
    .we    (accept && in_first),
    .waddr (ADDR_W'(load_count)),
    .wdata (element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mpm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_second_store (
    .clk   (clk),
    .we    (accept && !in_first),
    .waddr (ADDR_W'(load_count - n_first)),
    .wdata (element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Sequencer and shared multiply-accumulate unit.
  assign out_free = !product_valid || !product_stall;

  mpm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (mode_eff),
    .dim_r    (r_eff),
    .dim_k    (k_eff),
    .dim_c    (c_eff),
    .out_free (out_free),
    .a_addr   (a_raddr),
    .b_addr   (b_raddr),
    .ctrl     (mac_ctrl),
    .emit     (emit),
    .last     (seq_last),
    .busy     (busy)
  );

  mpm_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .result (mac_result),
    .sat    (mac_sat)
  );

  // Output register: holds one result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      product_valid <= 1'b0;
    end else if (emit) begin
      product_valid <= 1'b1;
    end else if (!product_stall) begin
      product_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      product_value <= $signed(mac_result);
      last_of_run   <= seq_last;
      saturated     <= mac_sat;
    end
  end

  // Checks on the interplay of loading, sequencing and the output register.
  `MPM_ASSERT_NEXT(a_start_busy, start, element_stall, "sequencer did not start after loading")
  `MPM_ASSERT_NOW(a_busy_count, busy, load_count == '0, "load count not cleared while computing")
  `MPM_ASSERT_NOW(a_emit_free, emit, out_free, "result written over an untaken beat")

endmodule

// ----- verif/matrix_product_modes_tb.sv -----
// Self-checking testbench of the matrix product block: directed runs, random runs, predictor.
module matrix_product_modes_tb;
  import mpm_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int DATA_W          = DATA_WIDTH_DEF;
  localparam int FRAC_W          = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS    = 320;
  localparam int IDLE_CYCLES     = 3 * MAX_DIM_DEF + 9;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TIMEOUT_CYCLES  = 2_000_000;
  localparam int N_RUNS          = 9;
  localparam int N_ELEMS         = 27;

  // Index writes that no register decodes.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;

  // How the element values of one random run are drawn.
  typedef enum {FILL_SMALL, FILL_WIDE, FILL_EDGE} fill_t;

  // One result beat as it should leave the block.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              sat;
  } product_beat_t;

  // One directed run: settings, number of element beats and, where obvious, its result.
  typedef struct packed {
    logic              write_cfg;
    logic [MODE_W-1:0] mode;
    logic [7:0]        rows;
    logic [7:0]        inner;
    logic [7:0]        cols;
    logic [7:0]        beats;
    logic              typed;
    logic [DATA_W-1:0] exp_value;
    logic              exp_sat;
  } run_row_t;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  element_valid = 1'b0;
  logic                  element_stall;
  logic [DATA_W-1:0]     element_value = '0;
  logic                  product_valid;
  logic                  product_stall = 1'b0;
  logic [DATA_W-1:0]     product_value;
  logic                  last_of_run;
  logic                  saturated;

  matrix_product_modes u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_valid (element_valid),
    .element_stall (element_stall),
    .element_value (element_value),
    .product_valid (product_valid),
    .product_stall (product_stall),
    .product_value (product_value),
    .last_of_run   (last_of_run),
    .saturated     (saturated)
  );

  // Directed runs. The first runs before any register write, so it sees the reset settings.
  run_row_t directed_runs [N_RUNS] = '{
    // Reset settings, 1.0 times 2.0.
    '{1'b0, MODE_MATRIX, 8'd1, 8'd1, 8'd1, 8'd2, 1'b1, 32'h0002_0000, 1'b0},
    // Largest positive squared clips high.
    '{1'b1, MODE_MATRIX, 8'd1, 8'd1, 8'd1, 8'd2, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // Most negative squared clips high as well.
    '{1'b1, MODE_MATRIX, 8'd1, 8'd1, 8'd1, 8'd2, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // Minus one LSB times one LSB rounds down to minus one LSB.
    '{1'b1, MODE_MATRIX, 8'd1, 8'd1, 8'd1, 8'd2, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // Elementwise, both results clip low.
    '{1'b1, MODE_ELEM,   8'd1, 8'd1, 8'd2, 8'd4, 1'b0, 32'h0,         1'b0},
    // Scalar times a two-element column.
    '{1'b1, MODE_SCALAR, 8'd2, 8'd1, 8'd1, 8'd3, 1'b0, 32'h0,         1'b0},
    // Partly loaded run, dropped by the next register write.
    '{1'b1, MODE_ELEM,   8'd2, 8'd1, 8'd2, 8'd1, 1'b0, 32'h0,         1'b0},
    // Spare mode code with zero dimensions: a 1x1x1 matrix product, 1.5 times -2.0.
    '{1'b1, MODE_SPARE,  8'd0, 8'd0, 8'd0, 8'd2, 1'b1, 32'hFFFD_0000, 1'b0},
    // Oversized rows clip to the maximum; high data bits are ignored.
    '{1'b1, MODE_SCALAR, 8'hF9, 8'hFF, 8'hF0, 8'd9, 1'b0, 32'h0,        1'b0}
  };

  logic [DATA_W-1:0] directed_elems [N_ELEMS] = '{
    32'h0001_0000, 32'h0002_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h0000_0001,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0003_0000,
    32'hFFFF_8000, 32'h0003_0000, 32'hFFFD_0001,
    32'h1234_5678,
    32'h0001_8000, 32'hFFFE_0000,
    32'h0002_0000, 32'h4000_0000, 32'hC000_0000, 32'hBFFF_FFFF, 32'h3FFF_FFFF,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_A5A5
  };

  // Predictor state: settings, operand stores and the load position.
  logic [MODE_W-1:0]    mode_q;
  logic [DIM_REG_W-1:0] rows_q, inner_q, cols_q;
  logic [DATA_W-1:0]    a_store [MAX_DIM_DEF * MAX_DIM_DEF];
  logic [DATA_W-1:0]    b_store [MAX_DIM_DEF * MAX_DIM_DEF];
  int                   loaded;
  product_beat_t        expected_products [$];
  int                   mismatches = 0;

  // A typed-in result that replaces the predicted final beat of the next run.
  logic              typed_armed = 1'b0;
  logic [DATA_W-1:0] typed_value;
  logic              typed_sat;

  // Settings as last written by the stimulus, used to size its runs.
  logic [7:0] drv_mode = '0, drv_rows = 8'd1, drv_inner = 8'd1, drv_cols = 8'd1;

  logic hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL");
    $finish;
  end

  // Zero counts as one and anything above the maximum is clipped.
  function automatic int dim_of(input logic [DIM_REG_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(raw);
  endfunction

  // Element counts of the first and second operand for the given settings.
  function automatic void operand_sizes(input logic [MODE_W-1:0] m,
                                        input logic [DIM_REG_W-1:0] rr, kr, cr,
                                        output int n1, output int n2);
    if (m == MODE_ELEM) begin
      n1 = dim_of(rr) * dim_of(cr);
      n2 = n1;
    end else if (m == MODE_SCALAR) begin
      n1 = 1;
      n2 = dim_of(rr) * dim_of(cr);
    end else begin
      n1 = dim_of(rr) * dim_of(kr);
      n2 = dim_of(kr) * dim_of(cr);
    end
  endfunction

  // Works out every product element once both operands are in, column-major.
  task automatic emit_products();
    int r, k, c, idx;
    logic signed [79:0] acc, prod, q, hi_lim, lo_lim;
    product_beat_t beat;
    r = dim_of(rows_q);
    k = dim_of(inner_q);
    c = dim_of(cols_q);
    hi_lim = (80'sd1 <<< (DATA_W - 1)) - 80'sd1;
    lo_lim = -(80'sd1 <<< (DATA_W - 1));
    for (int col = 0; col < c; col++) begin
      for (int row = 0; row < r; row++) begin
        idx = col * r + row;
        acc = '0;
        if (mode_q == MODE_ELEM) begin
          acc = $signed(a_store[idx]) * $signed(b_store[idx]);
        end else if (mode_q == MODE_SCALAR) begin
          acc = $signed(a_store[0]) * $signed(b_store[idx]);
        end else begin
          for (int j = 0; j < k; j++) begin
            prod = $signed(a_store[row + j * r]) * $signed(b_store[j + col * k]);
            acc  = acc + prod;
          end
        end
        // Floor by the fraction bits, then clip to the data width.
        q = acc >>> FRAC_W;
        beat.sat = 1'b0;
        if (q > hi_lim) begin
          q = hi_lim;
          beat.sat = 1'b1;
        end else if (q < lo_lim) begin
          q = lo_lim;
          beat.sat = 1'b1;
        end
        beat.value = q[DATA_W-1:0];
        beat.last  = (idx == r * c - 1);
        if (beat.last && typed_armed) begin
          beat.value  = typed_value;
          beat.sat    = typed_sat;
          typed_armed = 1'b0;
        end
        expected_products.push_back(beat);
      end
    end
  endtask

  // Stores one element beat and predicts the results once the run is complete.
  task automatic load_element(input logic [DATA_W-1:0] v);
    int n1, n2;
    operand_sizes(mode_q, rows_q, inner_q, cols_q, n1, n2);
    if (loaded < n1) a_store[loaded] = v;
    else b_store[loaded - n1] = v;
    loaded++;
    if (loaded == n1 + n2) begin
      loaded = 0;
      emit_products();
    end
  endtask

  // Compares one result beat with the oldest expectation.
  task automatic check_product();
    product_beat_t want;
    if (expected_products.size() == 0) begin
      $error("product beat with no expectation: product_value %h", product_value);
      mismatches++;
    end else begin
      want = expected_products.pop_front();
      if (product_value !== want.value) begin
        $error("product_value: expected %h, got %h", want.value, product_value);
        mismatches++;
      end
      if (last_of_run !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last_of_run);
        mismatches++;
      end
      if (saturated !== want.sat) begin
        $error("saturated: expected %b, got %b", want.sat, saturated);
        mismatches++;
      end
    end
  endtask

  // Observes every channel at the clock edge and keeps the predictor in step.
  always @(posedge clk) begin
    if (rst) begin
      mode_q  = MODE_MATRIX;
      rows_q  = 4'd1;
      inner_q = 4'd1;
      cols_q  = 4'd1;
      loaded  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRODUCT_MODE: begin mode_q  = cfg_data[MODE_W-1:0];    loaded = 0; end
          REG_ROWS_A:       begin rows_q  = cfg_data[DIM_REG_W-1:0]; loaded = 0; end
          REG_INNER_DIM:    begin inner_q = cfg_data[DIM_REG_W-1:0]; loaded = 0; end
          REG_COLS_B:       begin cols_q  = cfg_data[DIM_REG_W-1:0]; loaded = 0; end
          default: ;
        endcase
      end
      if (element_valid && !element_stall) load_element(element_value);
      if (product_valid && !product_stall) check_product();
    end
  end

  // Result side: stretches with no stall, random stalls, long stalls, and one hold-off.
  initial begin : result_sink
    int kind, span;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        product_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        kind = $urandom_range(0, 9);
        span = (kind == 9) ? $urandom_range(20, 120) : $urandom_range(1, 40);
        for (int n = 0; n < span; n++) begin
          if (kind < 4) product_stall <= 1'b0;
          else if (kind < 9) product_stall <= ($urandom_range(0, 2) == 0);
          else product_stall <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] dim_byte();
    logic [3:0] low, high;
    case ($urandom_range(0, 9))
      0:       low = 4'd0;
      1:       low = 4'd8;
      2:       low = 4'($urandom_range(9, 15));
      default: low = 4'($urandom_range(1, 3));
    endcase
    high = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
    return {high, low};
  endfunction

  function automatic logic [DATA_W-1:0] element_sample(input fill_t fill);
    logic [DATA_W-1:0] v;
    case (fill)
      FILL_SMALL: v = DATA_W'($urandom_range(0, 32'h7FFFF)) - 32'h0004_0000;
      FILL_WIDE:  v = $urandom;
      default: begin
        case ($urandom_range(0, 7))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'h0000_0001;
          4:       v = 32'hFFFF_FFFF;
          5:       v = 32'h0001_0000;
          6:       v = 32'hFFFF_0000;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  // Offers one element beat and returns at the edge that takes it.
  task automatic send_element(input logic [DATA_W-1:0] v, input int gap);
    element_valid <= 1'b1;
    element_value <= v;
    do @(negedge clk); while (element_stall);
    @(posedge clk);
    if (gap > 0) begin
      element_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one register write; the caller lowers valid after the last of a series.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_PRODUCT_MODE: drv_mode  = data;
      REG_ROWS_A:       drv_rows  = data;
      REG_INNER_DIM:    drv_inner = data;
      REG_COLS_B:       drv_cols  = data;
      default: ;
    endcase
  endtask

  // Waits until every expected result is out and the block has settled.
  // The half cycle lets the predictor book the beat taken at the last edge first.
  task automatic wait_idle();
    element_valid <= 1'b0;
    @(negedge clk);
    while (expected_products.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Rewrites some or all registers with random settings, extremes included.
  task automatic pick_settings(input bit all_regs);
    logic [5:0] noise;
    noise = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0;
    if (all_regs || $urandom_range(0, 1)) write_reg(REG_PRODUCT_MODE, {noise, MODE_W'($urandom)});
    if (all_regs || $urandom_range(0, 1)) write_reg(REG_ROWS_A, dim_byte());
    if (all_regs || $urandom_range(0, 1)) write_reg(REG_INNER_DIM, dim_byte());
    if (all_regs || $urandom_range(0, 1)) write_reg(REG_COLS_B, dim_byte());
    if ($urandom_range(0, 15) == 0)
      write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 3)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int pos, n1, n2, total, beats, sent;
    bit need_cfg, quit_early, steady, hold_asked;
    fill_t fill;
    run_row_t row;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed runs, walked row by row.
    pos = 0;
    for (int i = 0; i < N_RUNS; i++) begin
      row = directed_runs[i];
      wait_idle();
      if (row.write_cfg) begin
        write_reg(REG_PRODUCT_MODE, CFG_DATA_W'(row.mode));
        write_reg(REG_ROWS_A, row.rows);
        write_reg(REG_INNER_DIM, row.inner);
        write_reg(REG_COLS_B, row.cols);
        cfg_valid <= 1'b0;
      end
      typed_armed = row.typed;
      typed_value = row.exp_value;
      typed_sat   = row.exp_sat;
      for (int e = 0; e < row.beats; e++) begin
        send_element(directed_elems[pos], gap_len());
        pos++;
      end
    end

    // Random runs: mostly complete, sometimes back to back, now and then dropped part way.
    // While the hold-off is pending or running, runs follow each other with no register
    // writes, so element beats keep coming while the block is backed up.
    sent       = 0;
    need_cfg   = 1'b1;
    hold_asked = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (need_cfg || (!hold_off_req && $urandom_range(0, 3) != 0)) begin
        wait_idle();
        pick_settings(need_cfg);
      end
      operand_sizes(drv_mode[MODE_W-1:0], drv_rows[DIM_REG_W-1:0],
                    drv_inner[DIM_REG_W-1:0], drv_cols[DIM_REG_W-1:0], n1, n2);
      total      = n1 + n2;
      quit_early = !hold_off_req && (total > 1) && ($urandom_range(0, 19) == 0);
      beats      = quit_early ? $urandom_range(1, total - 1) : total;
      case ($urandom_range(0, 4))
        0, 1:    fill = FILL_SMALL;
        2:       fill = FILL_WIDE;
        default: fill = FILL_EDGE;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int e = 0; e < beats; e++) begin
        send_element(element_sample(fill), steady ? 0 : gap_len());
      end
      sent += beats;
      need_cfg = quit_early;
      // Once, let the result side hold off long enough for the block to back up.
      if (!hold_asked && !quit_early && sent >= 100) begin
        hold_off_req = 1'b1;
        hold_asked   = 1'b1;
      end
    end

    element_valid <= 1'b0;
    @(negedge clk);
    while (expected_products.size() != 0) @(posedge clk);
    repeat (4 * IDLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/mpm_pkg.sv
src/mpm_ram.sv
src/mpm_mac.sv
src/mpm_seq.sv
src/matrix_product_modes.sv
verif/matrix_product_modes_tb.sv
